// ===== rtl/ps2sc_pkg.sv =====
// Package for the PS/2 scan code set 2 event parser.
// Holds the prefix byte codes, the phase type and the event struct.
// No dependencies.
package ps2sc_pkg;

   localparam logic [7:0] CODE_BREAK   = 8'hF0;
   localparam logic [7:0] CODE_EXT     = 8'hE0;
   localparam logic [7:0] CODE_PAUSE   = 8'hE1;
   localparam logic [7:0] CODE_PRTSC_B = 8'h7C;
   localparam logic [7:0] CODE_PRTSC   = 8'h12;

   localparam logic [2:0] SKIP_PRTSC_MAKE  = 3'd2;
   localparam logic [2:0] SKIP_PRTSC_BREAK = 3'd3;
   localparam logic [2:0] SKIP_PAUSE       = 3'd7;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_BREAK     = 5'b00010,
      PH_EXT       = 5'b00100,
      PH_EXT_BREAK = 5'b01000,
      PH_SKIP      = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] key_code;
      logic       extended;
      logic       pressed;
      logic       pause_key;
   } event_type;

endpackage

// ===== rtl/ps2sc_decode.sv =====
// Prefix phase tracker: holds phase and skip count, decodes one byte per fire.
// Depends on ps2sc_pkg.
module ps2sc_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           scan_byte,
   output ps2sc_pkg::event_type ev
);

   ps2sc_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [2:0]           skip_ff, skip_in, skip_dec;

   always_comb begin
      phase_eff = phase_ff;
      // an empty skip counts as idle
      if (phase_ff == ps2sc_pkg::PH_SKIP && skip_ff == 3'd0) begin
         phase_eff = ps2sc_pkg::PH_IDLE;
      end
      skip_dec    = skip_ff - 3'd1;
      phase_in    = ps2sc_pkg::PH_IDLE;
      skip_in     = skip_ff;
      ev.hit      = 1'b0;
      ev.key_code = scan_byte;
      ev.extended = 1'b0;
      ev.pressed  = 1'b0;
      ev.pause_key = 1'b0;
      case (phase_eff)
         ps2sc_pkg::PH_SKIP: begin
            skip_in  = skip_dec;
            phase_in = (skip_dec == 3'd0) ? ps2sc_pkg::PH_IDLE : ps2sc_pkg::PH_SKIP;
         end
         ps2sc_pkg::PH_BREAK: begin
            ev.hit = 1'b1;
         end
         ps2sc_pkg::PH_EXT: begin
            if (scan_byte == ps2sc_pkg::CODE_BREAK) begin
               phase_in = ps2sc_pkg::PH_EXT_BREAK;
            end else begin
               ev.hit      = 1'b1;
               ev.extended = 1'b1;
               ev.pressed  = 1'b1;
               if (scan_byte == ps2sc_pkg::CODE_PRTSC) begin
                  phase_in = ps2sc_pkg::PH_SKIP;
                  skip_in  = ps2sc_pkg::SKIP_PRTSC_MAKE;
               end
            end
         end
         ps2sc_pkg::PH_EXT_BREAK: begin
            ev.hit      = 1'b1;
            ev.extended = 1'b1;
            if (scan_byte == ps2sc_pkg::CODE_PRTSC_B) begin
               ev.key_code = ps2sc_pkg::CODE_PRTSC;
               phase_in    = ps2sc_pkg::PH_SKIP;
               skip_in     = ps2sc_pkg::SKIP_PRTSC_BREAK;
            end
         end
         default: begin
            skip_in = 3'd0;
            if (scan_byte == ps2sc_pkg::CODE_BREAK) begin
               phase_in = ps2sc_pkg::PH_BREAK;
            end else if (scan_byte == ps2sc_pkg::CODE_EXT) begin
               phase_in = ps2sc_pkg::PH_EXT;
            end else if (scan_byte == ps2sc_pkg::CODE_PAUSE) begin
               ev.hit       = 1'b1;
               ev.key_code  = 8'h00;
               ev.pressed   = 1'b1;
               ev.pause_key = 1'b1;
               phase_in     = ps2sc_pkg::PH_SKIP;
               skip_in      = ps2sc_pkg::SKIP_PAUSE;
            end else begin
               ev.hit     = 1'b1;
               ev.pressed = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ps2sc_pkg::PH_IDLE;
         skip_ff  <= 3'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// ===== rtl/ps2sc_out_reg.sv =====
// Result register for key events, loaded from the decoder.
// Depends on ps2sc_pkg.
module ps2sc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ps2sc_pkg::event_type ev,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_key_code,
   output logic                 rsp_extended,
   output logic                 rsp_pressed,
   output logic                 rsp_pause_key
);

   logic                 valid_ff, valid_in;
   ps2sc_pkg::event_type data_ff;

   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = (load && ev.hit) || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && ev.hit) begin
         data_ff <= ev;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_key_code  = data_ff.key_code;
   assign rsp_extended  = data_ff.extended;
   assign rsp_pressed   = data_ff.pressed;
   assign rsp_pause_key = data_ff.pause_key;

endmodule

// ===== rtl/ps2sc_out_reg_unused_guard.sv =====
// Input register for received scan bytes, ahead of the decoder.
// Depends on nothing.
module ps2sc_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   input  logic       take,
   output logic       have,
   output logic [7:0] scan_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_scan_byte;
      end
   end

   assign have      = valid_ff;
   assign scan_byte = byte_ff;

endmodule

// ===== rtl/ps2_scan_code_event_parser.sv =====
// Top level of the PS/2 scan code set 2 event parser.
// Depends on ps2sc_pkg, ps2sc_in_reg, ps2sc_decode and ps2sc_out_reg.
//
// Takes one keyboard byte per cycle while req_stall is low and gives at most one
// key event per byte: the byte sits in an input register, the phase decode
// runs combinationally, and the event lands in a result register. Prefix
// bytes (F0, E0, E0 F0) and the trailing bytes of Print Screen and Pause give
// no event. A byte leaves the input register whenever the result register is
// empty or being taken, so under no back pressure the rate is one byte a cycle.
module ps2_scan_code_event_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_key_code,
   output logic       rsp_extended,
   output logic       rsp_pressed,
   output logic       rsp_pause_key
);

   logic                 have, room, fire;
   logic [7:0]           scan_byte;
   ps2sc_pkg::event_type ev;

   assign fire = have && room;

   ps2sc_in_reg u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_scan_byte (req_scan_byte),
      .take          (room),
      .have          (have),
      .scan_byte     (scan_byte)
   );

   ps2sc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .scan_byte (scan_byte),
      .ev        (ev)
   );

   ps2sc_out_reg u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (fire),
      .ev            (ev),
      .room          (room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_key_code  (rsp_key_code),
      .rsp_extended  (rsp_extended),
      .rsp_pressed   (rsp_pressed),
      .rsp_pause_key (rsp_pause_key)
   );

endmodule

// ===== rtl/ps2sc_checker.sv =====
// Port-level checks for the scan code event parser, bound to the top level.
// Depends on ps2_scan_code_event_parser ports only.
module ps2sc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_key_code,
   input logic       rsp_extended,
   input logic       rsp_pressed,
   input logic       rsp_pause_key
);

   // pause event has a fixed shape
   a_pause_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pause_key) |-> (rsp_key_code == 8'h00 && rsp_pressed && !rsp_extended))
      else $error("pause event malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_key_code) && $stable(rsp_extended)
         && $stable(rsp_pressed) && $stable(rsp_pause_key)))
      else $error("stalled result changed");

endmodule

bind ps2_scan_code_event_parser ps2sc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_key_code  (rsp_key_code),
   .rsp_extended  (rsp_extended),
   .rsp_pressed   (rsp_pressed),
   .rsp_pause_key (rsp_pause_key)
);
